// ===== rtl/mtt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_pkg : markup tag tokenizer shared definitions
// Phase encoding, token kinds, delimiter bytes and position limits.
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int DOC_BYTES = 65536;
    localparam int POS_MAX_INT = (DOC_BYTES - 1 < 65535) ? DOC_BYTES - 1 : 65535;
    localparam logic [15:0] POS_MAX = 16'(POS_MAX_INT);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [9:0] {
        PH_TOP         = 10'b00_0000_0001,
        PH_TAG_FIRST   = 10'b00_0000_0010,
        PH_TAG_NAME    = 10'b00_0000_0100,
        PH_CLOSE       = 10'b00_0000_1000,
        PH_ATTR_NAME   = 10'b00_0001_0000,
        PH_VALUE_OPEN  = 10'b00_0010_0000,
        PH_VALUE       = 10'b00_0100_0000,
        PH_AFTER_VALUE = 10'b00_1000_0000,
        PH_SKIP_TOP    = 10'b01_0000_0000,
        PH_TEXT        = 10'b10_0000_0000
    } phase_t;

    typedef enum logic [2:0] {
        K_OPEN  = 3'd0,
        K_SELF  = 3'd1,
        K_CLOSE = 3'd2,
        K_ATTR  = 3'd3,
        K_VALUE = 3'd4,
        K_TEXT  = 3'd5,
        K_END   = 3'd6,
        K_ERROR = 3'd7
    } token_kind_t;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic [15:0] token_length;
        logic [15:0] token_start;
        token_kind_t token_kind;
    } token_t;

    // non-negative distance, zero when the start lies beyond the end
    function automatic logic [15:0] span(input logic [15:0] from, input logic [15:0] upto);
        span = (from > upto) ? 16'd0 : upto - from;
    endfunction

endpackage : mtt_pkg
`default_nettype wire

// ===== rtl/markup_tag_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// markup_tag_tokenizer : byte-stream markup tokenizer
// Takes one document byte per request and emits tag, attribute, value,
// text, end and error tokens with start offset and length.
// ----------------------------------------------------------------------------
// A token appears on m_tvalid in the cycle after the byte that ends it.
// Throughput: one byte per cycle; s_tready drops only while a token sits in
// the output register and m_tready is low.
// Reset: synchronous, active low; phase to top level, position and token
// start to zero, output register emptied.
module markup_tag_tokenizer
    import mtt_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [2:0] token_kind, [18:3] token_start,
                                              // [34:19] token_length, [39:35] zero
);

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] tbegin_reg, tbegin_next;
    logic        m_valid_reg;
    token_t      tok_reg;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] len_cur;
    logic [15:0] tb_name;
    logic [15:0] len_name;
    logic [16:0] len_close;
    logic        emit;
    token_t      tok;
    logic        do_top;

    assign b        = s_tdata;
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pos_next = (pos_reg < POS_MAX) ? pos_reg + 16'd1 : pos_reg;
    assign len_cur  = span(tbegin_reg, pos_reg);
    // first name byte restarts the token at the current position
    assign tb_name  = (phase_reg == PH_TAG_FIRST) ? pos_reg : tbegin_reg;
    assign len_name = span(tb_name, pos_reg);
    assign len_close = {1'b0, len_cur} + 17'd1;

    always_comb begin
        phase_next  = phase_reg;
        tbegin_next = tbegin_reg;
        emit        = 1'b0;
        do_top      = 1'b0;
        tok.token_kind   = K_OPEN;
        tok.token_start  = tbegin_reg;
        tok.token_length = len_cur;

        if (b == CH_NUL && phase_reg != PH_TOP) begin
            emit           = 1'b1;
            tok.token_kind = K_ERROR;
            phase_next     = PH_TOP;
        end else begin
            unique case (phase_reg)
                PH_TAG_FIRST, PH_TAG_NAME: begin
                    if (phase_reg == PH_TAG_FIRST && b == CH_SLASH) begin
                        phase_next = PH_CLOSE;
                    end else begin
                        tbegin_next      = tb_name;
                        phase_next       = PH_TAG_NAME;
                        tok.token_start  = tb_name;
                        tok.token_length = len_name;
                        if (b == CH_SPACE) begin
                            emit        = 1'b1;
                            phase_next  = PH_ATTR_NAME;
                            tbegin_next = pos_next;
                        end else if (b == CH_SLASH) begin
                            emit           = 1'b1;
                            tok.token_kind = K_SELF;
                            phase_next     = PH_SKIP_TOP;
                        end else if (b == CH_GT) begin
                            emit       = 1'b1;
                            phase_next = PH_TOP;
                        end
                    end
                end
                PH_CLOSE: begin
                    if (b == CH_GT) begin
                        emit             = 1'b1;
                        tok.token_kind   = K_CLOSE;
                        tok.token_length = len_close[16] ? 16'hFFFF : len_close[15:0];
                        phase_next       = PH_TOP;
                    end
                end
                PH_ATTR_NAME: begin
                    tok.token_kind = K_ATTR;
                    if (b == CH_SPACE) begin
                        emit        = 1'b1;
                        tbegin_next = pos_next;
                    end else if (b == CH_GT) begin
                        emit       = 1'b1;
                        phase_next = PH_TOP;
                    end else if (b == CH_SLASH) begin
                        emit       = 1'b1;
                        phase_next = PH_SKIP_TOP;
                    end else if (b == CH_EQ) begin
                        emit       = 1'b1;
                        phase_next = PH_VALUE_OPEN;
                    end
                end
                PH_VALUE_OPEN: begin
                    // byte after '=' is the opening quote, value starts after it
                    tbegin_next = pos_next;
                    phase_next  = PH_VALUE;
                end
                PH_VALUE: begin
                    if (b == CH_QUOTE) begin
                        emit           = 1'b1;
                        tok.token_kind = K_VALUE;
                        phase_next     = PH_AFTER_VALUE;
                    end
                end
                PH_AFTER_VALUE: begin
                    if (b == CH_SPACE) begin
                        tbegin_next = pos_next;
                        phase_next  = PH_ATTR_NAME;
                    end else if (b == CH_GT) begin
                        phase_next = PH_TOP;
                    end else if (b == CH_SLASH) begin
                        phase_next = PH_SKIP_TOP;
                    end else begin
                        do_top = 1'b1;
                    end
                end
                PH_SKIP_TOP: begin
                    phase_next = PH_TOP;
                end
                PH_TEXT: begin
                    if (b == CH_LT) begin
                        emit           = 1'b1;
                        tok.token_kind = K_TEXT;
                        tbegin_next    = pos_reg;
                        phase_next     = PH_TAG_FIRST;
                    end
                end
                default: begin
                    do_top = 1'b1;
                end
            endcase
        end

        // top level byte: whitespace skip, end of document, or start of token
        if (do_top) begin
            if (b == CH_LF || b == CH_CR || b == CH_TAB) begin
                phase_next = PH_TOP;
            end else if (b == CH_NUL) begin
                emit             = 1'b1;
                tok.token_kind   = K_END;
                tok.token_start  = pos_reg;
                tok.token_length = 16'd1;
                phase_next       = PH_TOP;
            end else begin
                tbegin_next = pos_reg;
                phase_next  = (b == CH_LT) ? PH_TAG_FIRST : PH_TEXT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TOP;
            pos_reg     <= 16'd0;
            tbegin_reg  <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                tbegin_reg <= tbegin_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            tok_reg <= tok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, tok_reg};

endmodule : markup_tag_tokenizer
`default_nettype wire
